// ===== rtl/core/deadline_sorted_alarm_queue_unit_defines.svh =====
// Assertion helpers, clocked on clk, quiet while rst_n is low.
`ifndef DEADLINE_SORTED_ALARM_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_SORTED_ALARM_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DSAQ_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSAQ_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dsaq_pkg.sv =====
`default_nettype none
package dsaq_pkg;

  localparam int SlotsDef     = 16;
  localparam int DueMax       = 16;
  localparam logic [7:0] SafeDeltaRst = 8'd3;

  typedef enum logic [1:0] {
    KIND_SCHED_ABS = 2'd0,
    KIND_SCHED_OFF = 2'd1,
    KIND_CANCEL    = 2'd2,
    KIND_SERVICE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_UNSCHED = 2'd0,
    ST_SCHED   = 2'd1,
    ST_CANCEL  = 2'd2
  } status_t;

  // one due alarm handed to the result side
  typedef struct packed {
    logic       vld;
    logic [3:0] idx;
    logic [3:0] id;
  } push_t;

  // end-of-request summary
  typedef struct packed {
    logic        vld;
    logic [4:0]  ndue;
    logic [1:0]  prior;
    logic        hc;
    logic        cv;
    logic [31:0] cval;
  } summ_t;

endpackage
`default_nettype wire

// ===== rtl/core/dsaq_ram.sv =====
`default_nettype none
module dsaq_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/dsaq_seq.sv =====
`default_nettype none
module dsaq_seq #(
  parameter int SLOTS = dsaq_pkg::SlotsDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_kind,
  input  wire logic [3:0]           in_alarm_id,
  input  wire logic [31:0]          in_deadline,
  input  wire logic signed [31:0]   in_offset,
  input  wire logic [31:0]          in_interval,
  input  wire logic [31:0]          in_now,
  input  wire logic [7:0]           safe_delta,
  input  wire logic                 emit_busy,
  output dsaq_pkg::push_t           push,
  output dsaq_pkg::summ_t           summ
);
  import dsaq_pkg::*;

  localparam int IDW = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_REM_RD, S_REM_CHK, S_SCHED_WR, S_INS_RD, S_INS_DL, S_INS_CMP,
    S_SV_RD, S_SV_DL, S_SV_CMP, S_CP_RD, S_CP_WR, S_RI_RD, S_RI_UPD,
    S_RI_NEXT, S_FIN, S_FIN_CV, S_DONE
  } state_t;

  state_t          state_r, state_nxt, ret_r, ret_nxt;
  kind_t           kind_r, kind_nxt;
  logic [IDW-1:0]  slot_r, slot_nxt, v_r, v_nxt, carry_r, carry_nxt;
  logic [IDW-1:0]  ins_id_r, ins_id_nxt, head_r, head_nxt, bhead_r, bhead_nxt;
  logic [31:0]     dl_r, dl_nxt, off_r, off_nxt, iv_r, iv_nxt, now_r, now_nxt;
  logic [31:0]     ins_d_r, ins_d_nxt, cval_r, cval_nxt;
  logic [CW-1:0]   i_r, i_nxt, cnt_r, cnt_nxt;
  logic            found_r, found_nxt, placed_r, placed_nxt, bcnt0_r, bcnt0_nxt;
  logic            cv_r, cv_nxt;
  logic [4:0]      ndue_r, ndue_nxt, k_r, k_nxt;
  logic [1:0]      prior_r, prior_nxt;
  status_t         status_r [SLOTS];
  status_t         status_nxt [SLOTS];
  logic [IDW-1:0]  due_r [DueMax];
  logic [IDW-1:0]  due_nxt [DueMax];

  logic            ord_we, dl_we, iv_we;
  logic [IDW-1:0]  ord_wa, ord_ra, ord_wd, ord_rd, dl_wa, dl_ra;
  logic [31:0]     dl_wd, dl_rd, iv_wd, iv_rd;

  logic [IDW+3:0]  id_ext;
  logic [IDW-1:0]  in_slot;
  logic            in_ok;
  logic [CW-1:0]   im1, src;
  logic [31:0]     nd, dv, sd, dsel;
  logic [IDW+3:0]  v_ext;
  logic            cnt0;

  dsaq_ram #(.W(IDW), .D(SLOTS)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd)
  );
  dsaq_ram #(.W(32), .D(SLOTS)) u_dline (
    .clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd), .raddr(dl_ra), .rdata(dl_rd)
  );
  dsaq_ram #(.W(32), .D(SLOTS)) u_ival (
    .clk(clk), .we(iv_we), .waddr(dl_wa), .wdata(iv_wd), .raddr(dl_ra), .rdata(iv_rd)
  );

  assign id_ext   = {{IDW{1'b0}}, in_alarm_id};
  assign in_slot  = id_ext[IDW-1:0];
  assign in_ok    = 32'(in_alarm_id) < SLOTS;
  assign in_ready = (state_r == S_IDLE) && !emit_busy;
  assign im1      = i_r - 1'b1;
  assign src      = i_r + CW'(ndue_r);
  assign dv       = dl_rd - now_r;
  assign sd       = {24'd0, safe_delta};
  assign v_ext    = {4'd0, v_r};
  assign cnt0     = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;     kind_nxt = kind_r;
    slot_nxt = slot_r;     v_nxt = v_r;         carry_nxt = carry_r;
    ins_id_nxt = ins_id_r; bhead_nxt = bhead_r; head_nxt = head_r;
    dl_nxt = dl_r;  off_nxt = off_r;  iv_nxt = iv_r;  now_nxt = now_r;
    ins_d_nxt = ins_d_r;   cval_nxt = cval_r;   cv_nxt = cv_r;
    i_nxt = i_r;  cnt_nxt = cnt_r;  found_nxt = found_r;  placed_nxt = placed_r;
    bcnt0_nxt = bcnt0_r;   ndue_nxt = ndue_r;   k_nxt = k_r;  prior_nxt = prior_r;
    status_nxt = status_r; due_nxt = due_r;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    dl_we = 1'b0;  iv_we = 1'b0; dl_wa = '0; dl_wd = '0; iv_wd = '0; dl_ra = '0;
    nd = '0;  dsel = '0;
    push = '0; summ = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          kind_nxt = kind_t'(in_kind);
          slot_nxt = in_slot;
          dl_nxt = in_deadline;  off_nxt = in_offset;
          iv_nxt = in_interval;  now_nxt = in_now;
          bhead_nxt = head_r;    bcnt0_nxt = cnt0;
          prior_nxt = '0;  ndue_nxt = '0;  i_nxt = '0;  found_nxt = 1'b0;
          case (kind_t'(in_kind))
            KIND_SCHED_ABS, KIND_SCHED_OFF: begin
              if (!in_ok) begin
                state_nxt = S_FIN;
              end else if (status_r[in_slot] == ST_SCHED) begin
                ret_nxt = S_SCHED_WR;
                state_nxt = S_REM_RD;
              end else begin
                state_nxt = S_SCHED_WR;
              end
            end
            KIND_CANCEL: begin
              state_nxt = S_FIN;
              if (in_ok) begin
                prior_nxt = status_r[in_slot];
                if (status_r[in_slot] == ST_SCHED) begin
                  status_nxt[in_slot] = ST_CANCEL;
                  ret_nxt = S_FIN;
                  state_nxt = S_REM_RD;
                end
              end
            end
            default: state_nxt = S_SV_RD;
          endcase
        end
      end
      // unlink slot_r: everything after it moves up one place
      S_REM_RD: begin
        if (i_r == cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = ret_r;
        end else begin
          ord_ra = i_r[IDW-1:0];
          state_nxt = S_REM_CHK;
        end
      end
      S_REM_CHK: begin
        if (found_r) begin
          ord_we = 1'b1;  ord_wa = im1[IDW-1:0];  ord_wd = ord_rd;
        end
        if (ord_rd == slot_r) found_nxt = 1'b1;
        i_nxt = i_r + 1'b1;
        state_nxt = S_REM_RD;
      end
      S_SCHED_WR: begin
        nd = (kind_r == KIND_SCHED_ABS) ? dl_r : now_r + off_r;
        dl_we = 1'b1;  iv_we = 1'b1;  dl_wa = slot_r;  dl_wd = nd;  iv_wd = iv_r;
        ins_id_nxt = slot_r;
        ins_d_nxt = nd - now_r;
        i_nxt = '0;  placed_nxt = 1'b0;
        ret_nxt = S_FIN;
        state_nxt = S_INS_RD;
      end
      // forward insert: place ins_id before the first strictly later entry,
      // then carry the displaced entries one place back
      S_INS_RD: begin
        if (i_r == cnt_r) begin
          if (32'(cnt_r) < SLOTS) begin
            ord_we = 1'b1;  ord_wa = cnt_r[IDW-1:0];
            ord_wd = placed_r ? carry_r : ins_id_r;
            cnt_nxt = cnt_r + 1'b1;
            status_nxt[ins_id_r] = ST_SCHED;
          end
          state_nxt = ret_r;
        end else begin
          ord_ra = i_r[IDW-1:0];
          state_nxt = S_INS_DL;
        end
      end
      S_INS_DL: begin
        v_nxt = ord_rd;  dl_ra = ord_rd;
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (placed_r) begin
          ord_we = 1'b1;  ord_wa = i_r[IDW-1:0];  ord_wd = carry_r;  carry_nxt = v_r;
        end else if ($signed(ins_d_r) < $signed(dv)) begin
          ord_we = 1'b1;  ord_wa = i_r[IDW-1:0];  ord_wd = ins_id_r;
          carry_nxt = v_r;  placed_nxt = 1'b1;
        end
        i_nxt = i_r + 1'b1;
        state_nxt = S_INS_RD;
      end
      // service: collect due entries from the front
      S_SV_RD: begin
        if (i_r == cnt_r || ndue_r == 5'(DueMax)) begin
          i_nxt = '0;
          state_nxt = (ndue_r == '0) ? S_FIN : S_CP_RD;
        end else begin
          ord_ra = i_r[IDW-1:0];
          state_nxt = S_SV_DL;
        end
      end
      S_SV_DL: begin
        v_nxt = ord_rd;  dl_ra = ord_rd;
        state_nxt = S_SV_CMP;
      end
      S_SV_CMP: begin
        if ($signed(dv) <= 0) begin
          due_nxt[ndue_r[3:0]] = v_r;
          push.vld = 1'b1;  push.idx = ndue_r[3:0];  push.id = v_ext[3:0];
          ndue_nxt = ndue_r + 1'b1;
          i_nxt = i_r + 1'b1;
          state_nxt = S_SV_RD;
        end else begin
          i_nxt = '0;
          state_nxt = (ndue_r == '0) ? S_FIN : S_CP_RD;
        end
      end
      S_CP_RD: begin
        if (src < cnt_r) begin
          ord_ra = src[IDW-1:0];
          state_nxt = S_CP_WR;
        end else begin
          cnt_nxt = cnt_r - CW'(ndue_r);
          k_nxt = '0;
          state_nxt = S_RI_RD;
        end
      end
      S_CP_WR: begin
        ord_we = 1'b1;  ord_wa = i_r[IDW-1:0];  ord_wd = ord_rd;
        i_nxt = i_r + 1'b1;
        state_nxt = S_CP_RD;
      end
      S_RI_RD: begin
        if (k_r == ndue_r) begin
          state_nxt = S_FIN;
        end else begin
          dl_ra = due_r[k_r[3:0]];
          v_nxt = due_r[k_r[3:0]];
          state_nxt = S_RI_UPD;
        end
      end
      S_RI_UPD: begin
        nd = dl_rd + iv_rd;
        dl_we = 1'b1;  dl_wa = v_r;  dl_wd = nd;
        if (iv_rd != '0) begin
          ins_id_nxt = v_r;  ins_d_nxt = nd - now_r;
          i_nxt = '0;  placed_nxt = 1'b0;
          ret_nxt = S_RI_NEXT;
          state_nxt = S_INS_RD;
        end else begin
          status_nxt[v_r] = ST_UNSCHED;
          state_nxt = S_RI_NEXT;
        end
      end
      S_RI_NEXT: begin
        k_nxt = k_r + 1'b1;
        state_nxt = S_RI_RD;
      end
      S_FIN: begin
        if (cnt0) begin
          cv_nxt = 1'b0;  cval_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          dl_ra = head_r;
          state_nxt = S_FIN_CV;
        end
      end
      S_FIN_CV: begin
        dsel = ($signed(dv) < $signed(sd)) ? sd : dv;
        cv_nxt = 1'b1;
        cval_nxt = now_r + dsel;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        summ.vld   = 1'b1;
        summ.ndue  = ndue_r;
        summ.prior = prior_r;
        summ.hc    = (bcnt0_r != cnt0) || (!cnt0 && !bcnt0_r && head_r != bhead_r);
        summ.cv    = cv_r;
        summ.cval  = cval_r;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // head register mirrors entry 0 of the order list
    if (ord_we && ord_wa == '0) head_nxt = ord_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_FIN;
      cnt_r   <= '0;
      for (int s = 0; s < SLOTS; s++) status_r[s] <= ST_UNSCHED;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
    end
    kind_r <= kind_nxt;   slot_r <= slot_nxt;   v_r <= v_nxt;   carry_r <= carry_nxt;
    ins_id_r <= ins_id_nxt;  head_r <= head_nxt;  bhead_r <= bhead_nxt;
    dl_r <= dl_nxt;  off_r <= off_nxt;  iv_r <= iv_nxt;  now_r <= now_nxt;
    ins_d_r <= ins_d_nxt;  cval_r <= cval_nxt;  cv_r <= cv_nxt;
    i_r <= i_nxt;  found_r <= found_nxt;  placed_r <= placed_nxt;  bcnt0_r <= bcnt0_nxt;
    ndue_r <= ndue_nxt;  k_r <= k_nxt;  prior_r <= prior_nxt;  due_r <= due_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/deadline_sorted_alarm_queue_unit.sv =====
// channel | dir | handshake            | payload
// in_     | in  | in_valid / in_ready   | kind, alarm_id, deadline, offset, interval, now
// out_    | out | out_valid / out_ready | due_valid, due_id, last, prior_state,
//         |     |                      |   head_changed, compare_valid, compare_value
// cfg_    | in  | cfg_valid / cfg_ready | safe_delta (always ready)
//
// One request at a time; N queued alarms. Schedule unlinks the slot if it is already
// scheduled, then writes the deadline and interval and inserts it. Cancel unlinks it.
// Service collects the due alarms from the front, moves the rest up, drops one-shots
// and reinserts periodic ones; the compare value and the summary follow.
// Results stream one per cycle while out_ready is high; in_ready stays low until the
// last one is taken. Synchronous reset empties the queue; safe_delta returns to 3.
`default_nettype none
module deadline_sorted_alarm_queue_unit #(
  parameter int SLOTS = dsaq_pkg::SlotsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_kind,
  input  wire logic [3:0]         in_alarm_id,
  input  wire logic [31:0]        in_deadline,
  input  wire logic signed [31:0] in_offset,
  input  wire logic [31:0]        in_interval,
  input  wire logic [31:0]        in_now,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_due_valid,
  output logic [3:0]              out_due_id,
  output logic                    out_last,
  output logic [1:0]              out_prior_state,
  output logic                    out_head_changed,
  output logic                    out_compare_valid,
  output logic [31:0]             out_compare_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_safe_delta
);
  import dsaq_pkg::*;
`include "deadline_sorted_alarm_queue_unit_defines.svh"

  logic [7:0]  safe_r;
  push_t       push;
  summ_t       summ;

  // result side: due ids collected during service, then replayed
  logic        busy_r;
  logic [4:0]  ndue_r;
  logic [3:0]  idx_r;
  logic [1:0]  prior_r;
  logic        hc_r, cv_r;
  logic [31:0] cval_r;
  logic [3:0]  due_r [DueMax];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_r <= SafeDeltaRst;
    end else if (cfg_valid) begin
      safe_r <= cfg_safe_delta;
    end
  end

  dsaq_seq #(.SLOTS(SLOTS)) u_seq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_alarm_id(in_alarm_id), .in_deadline(in_deadline),
    .in_offset(in_offset), .in_interval(in_interval), .in_now(in_now),
    .safe_delta(safe_r), .emit_busy(busy_r),
    .push(push), .summ(summ)
  );

  assign out_valid         = busy_r;
  assign out_due_valid     = (ndue_r != '0);
  assign out_due_id        = out_due_valid ? due_r[idx_r] : 4'd0;
  assign out_last          = !out_due_valid || (5'(idx_r) + 5'd1 == ndue_r);
  assign out_prior_state   = prior_r;
  assign out_head_changed  = hc_r;
  assign out_compare_valid = cv_r;
  assign out_compare_value = cval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (summ.vld) begin
      busy_r <= 1'b1;
    end else if (out_valid && out_ready && out_last) begin
      busy_r <= 1'b0;
    end
    if (push.vld) due_r[push.idx] <= push.id;
    if (summ.vld) begin
      idx_r   <= '0;
      ndue_r  <= summ.ndue;
      prior_r <= summ.prior;
      hc_r    <= summ.hc;
      cv_r    <= summ.cv;
      cval_r  <= summ.cval;
    end else if (out_valid && out_ready && !out_last) begin
      idx_r <= idx_r + 4'd1;
    end
  end

  // a new request is never taken while results are pending
  `DSAQ_CHK_NOW(a_one_at_a_time, in_ready, !out_valid, "input ready while results pending")
  // a request with nothing due gives exactly one result
  `DSAQ_CHK_NOW(a_single_last, out_valid && !out_due_valid, out_last, "lone result not last")
  // the final result ends the burst
  `DSAQ_CHK_NXT(a_burst_end, out_valid && out_ready && out_last, !out_valid,
                "result after last")

endmodule
`default_nettype wire
